[hdl/rsc_pkg.sv]
// Shared types, field widths and command codes of the register slot cache.
`timescale 1ns / 1ps
package rsc_pkg;

  localparam int CMD_W   = 4;
  localparam int REG_W   = 5;
  localparam int WORD_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int KIND_W  = 2;

  localparam int DEF_NUM_SLOTS      = 6;
  localparam int DEF_NUM_GUEST_REGS = 32;
  localparam int DEF_WORDS_PER_REG  = 4;
  localparam int DEF_STAMP_WIDTH    = 32;
  localparam int CMDQ_DEPTH         = 2;
  localparam int RESQ_DEPTH         = 2;

  localparam logic [CMD_W-1:0] CMD_GET        = 4'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_DIRTY = 4'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FREE       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH_ALL  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FREE_ALL   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CHECK_USED = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;

  localparam logic [KIND_W-1:0] KIND_ANSWER    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REG_W-1:0]  guest_reg;
    logic [WORD_W-1:0] word_sel;
    logic [SLOT_W-1:0] slot_sel;
    logic              load;
    logic              sok;
    logic              gok;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [REG_W-1:0]  guest_reg;
    logic [WORD_W-1:0] word;
    logic              hit;
    logic              in_use;
    logic              last;
  } res_t;

endpackage

[hdl/rsc_fifo.sv]
// Small first-in first-out queue used between the stages.
`timescale 1ns / 1ps
module rsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[hdl/rsc_front.sv]
// Front end: takes requests, range-checks them and queues them for the back end.
`timescale 1ns / 1ps
module rsc_front import rsc_pkg::*; #(
  parameter int NUM_SLOTS      = DEF_NUM_SLOTS,
  parameter int NUM_GUEST_REGS = DEF_NUM_GUEST_REGS,
  parameter int WORDS_PER_REG  = DEF_WORDS_PER_REG
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  command,
  input  logic [REG_W-1:0]  guest_reg,
  input  logic [WORD_W-1:0] word_sel,
  input  logic [SLOT_W-1:0] slot_sel,
  input  logic              load_on_miss,
  input  logic              cmd_pop,
  output cmd_t              cmd,
  output logic              cmd_empty
);
  cmd_t                 cls;
  logic [$bits(cmd_t)-1:0] q_out;

  always_comb begin
    cls.cmd       = command;
    cls.guest_reg = guest_reg;
    cls.word_sel  = word_sel;
    cls.slot_sel  = slot_sel;
    cls.load      = load_on_miss;
    cls.sok       = 32'(slot_sel) < NUM_SLOTS;
    cls.gok       = (32'(guest_reg) < NUM_GUEST_REGS) && (32'(word_sel) < WORDS_PER_REG);
  end

  rsc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .wr_en(push),
    .din  (cls),
    .full (full),
    .rd_en(cmd_pop),
    .dout (q_out),
    .empty(cmd_empty)
  );

  assign cmd = cmd_t'(q_out);
endmodule

[hdl/rsc_back.sv]
// Back end: slot state, replacement scan and emission of actions and answers.
`timescale 1ns / 1ps
module rsc_back import rsc_pkg::*; #(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_EVICT  = 7'b0001000,
    S_ALLOC  = 7'b0010000,
    S_WB     = 7'b0100000,
    S_ANSWER = 7'b1000000
  } state_t;

  state_t                 state;
  cmd_t                   cur;
  logic                   used      [NUM_SLOTS];
  logic                   dirty     [NUM_SLOTS];
  logic [STAMP_WIDTH-1:0] stamp     [NUM_SLOTS];
  logic [REG_W-1:0]       owner_reg [NUM_SLOTS];
  logic [WORD_W-1:0]      owner_word[NUM_SLOTS];
  logic [STAMP_WIDTH-1:0] counter;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          best;
  logic [IW-1:0]          target;
  logic [SLOT_W-1:0]      ans_slot;
  logic                   ans_hit;
  logic                   ans_used;

  logic                   hit_any;
  logic [IW-1:0]          hit_slot;
  logic                   free_any;
  logic [IW-1:0]          free_slot;
  logic [IW-1:0]          ss;
  logic [IW-1:0]          best_next;
  logic                   go;

  assign ss = IW'(cur.slot_sel);

  // Associative lookup over the slot owners stands in for the map table.
  always_comb begin
    hit_any   = 1'b0;
    hit_slot  = '0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (used[s] && owner_reg[s] == cur.guest_reg && owner_word[s] == cur.word_sel) begin
        hit_any  = cur.gok;
        hit_slot = IW'(s);
      end
      if (!used[s]) begin
        free_any  = 1'b1;
        free_slot = IW'(s);
      end
    end
  end

  assign best_next = (stamp[idx] < stamp[best]) ? idx : best;

  always_comb begin
    res_push = 1'b0;
    res      = '0;
    case (state)
      S_EVICT: begin
        res_push      = used[target] && dirty[target];
        res.kind      = KIND_WRITEBACK;
        res.slot      = SLOT_W'(target);
        res.guest_reg = owner_reg[target];
        res.word      = owner_word[target];
      end
      S_WB: begin
        res_push      = used[idx] && dirty[idx];
        res.kind      = KIND_WRITEBACK;
        res.slot      = SLOT_W'(idx);
        res.guest_reg = owner_reg[idx];
        res.word      = owner_word[idx];
      end
      S_ALLOC: begin
        res_push      = cur.load;
        res.kind      = KIND_LOAD;
        res.slot      = SLOT_W'(target);
        res.guest_reg = cur.guest_reg;
        res.word      = cur.word_sel;
      end
      S_ANSWER: begin
        res_push    = 1'b1;
        res.kind    = KIND_ANSWER;
        res.slot    = ans_slot;
        res.hit     = ans_hit;
        res.in_use  = ans_used;
        res.last    = 1'b1;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  assign go      = !res_push || !res_full;
  assign cmd_pop = (state == S_IDLE) && !cmd_empty;

  always_ff @(posedge clk) begin
    if (rst || (state == S_DECIDE && cur.cmd == CMD_CLEAR)) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        used[s]       <= 1'b0;
        dirty[s]      <= 1'b0;
        stamp[s]      <= '0;
        owner_reg[s]  <= '0;
        owner_word[s] <= '0;
      end
      counter <= STAMP_WIDTH'(1);
    end else begin
      case (state)
        S_DECIDE: begin
          if (cur.sok && cur.cmd == CMD_MARK_DIRTY) begin
            dirty[ss] <= 1'b1;
          end
          if (cur.sok && cur.cmd == CMD_TOUCH) begin
            stamp[ss] <= counter;
            if (counter != '1) begin
              counter <= counter + 1'b1;
            end
          end
        end
        S_EVICT: begin
          if (go) begin
            used[target]       <= 1'b0;
            dirty[target]      <= 1'b0;
            stamp[target]      <= '0;
            owner_reg[target]  <= '0;
            owner_word[target] <= '0;
          end
        end
        S_ALLOC: begin
          if (go) begin
            used[target]       <= 1'b1;
            owner_reg[target]  <= cur.guest_reg;
            owner_word[target] <= cur.word_sel;
            stamp[target]      <= counter;
            if (counter != '1) begin
              counter <= counter + 1'b1;
            end
          end
        end
        S_WB: begin
          // Single flush drops the dirty bit of a used slot; flush all keeps it.
          if (go && cur.cmd == CMD_FLUSH && used[idx]) begin
            dirty[idx] <= 1'b0;
          end
        end
        default: begin
          counter <= counter;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            cur   <= cmd;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ans_slot <= '0;
          ans_hit  <= 1'b0;
          ans_used <= 1'b0;
          state    <= S_ANSWER;
          case (cur.cmd)
            CMD_GET: begin
              if (cur.gok && hit_any) begin
                ans_slot <= SLOT_W'(hit_slot);
                ans_hit  <= 1'b1;
              end else if (cur.gok && free_any) begin
                target <= free_slot;
                state  <= S_ALLOC;
              end else if (cur.gok) begin
                idx   <= IW'(1);
                best  <= '0;
                state <= S_SCAN;
              end
            end
            CMD_MARK_DIRTY, CMD_TOUCH: begin
              ans_slot <= cur.slot_sel;
            end
            CMD_FREE: begin
              ans_slot <= cur.slot_sel;
              if (cur.sok) begin
                target <= ss;
                state  <= S_EVICT;
              end
            end
            CMD_FLUSH: begin
              ans_slot <= cur.slot_sel;
              if (cur.sok) begin
                idx   <= ss;
                state <= S_WB;
              end
            end
            CMD_FLUSH_ALL: begin
              idx   <= '0;
              state <= S_WB;
            end
            CMD_FREE_ALL: begin
              target <= '0;
              state  <= S_EVICT;
            end
            CMD_QUERY: begin
              if (hit_any) begin
                ans_slot <= SLOT_W'(hit_slot);
                ans_hit  <= 1'b1;
              end
            end
            CMD_CHECK_USED: begin
              ans_slot <= cur.slot_sel;
              ans_used <= cur.sok && used[ss];
            end
            default: begin
              ans_slot <= '0;
            end
          endcase
        end
        S_SCAN: begin
          best <= best_next;
          idx  <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            target <= best_next;
            state  <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (go) begin
            if (cur.cmd == CMD_GET) begin
              state <= S_ALLOC;
            end else if (cur.cmd == CMD_FREE_ALL && target != LAST_IDX) begin
              target <= target + 1'b1;
            end else begin
              state <= S_ANSWER;
            end
          end
        end
        S_ALLOC: begin
          if (go) begin
            ans_slot <= SLOT_W'(target);
            state    <= S_ANSWER;
          end
        end
        S_WB: begin
          if (go) begin
            if (cur.cmd == CMD_FLUSH_ALL && idx != LAST_IDX) begin
              idx <= idx + 1'b1;
            end else begin
              state <= S_ANSWER;
            end
          end
        end
        S_ANSWER: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

[hdl/register_slot_cache_lru.sv]
// Top level of the register slot cache with least-recently-stamped replacement.
//
//   channel   handshake      fields
//   request   push / full    command, guest_reg, word_sel, slot_sel, load_on_miss
//   result    pop / empty    kind, slot, out_guest_reg, out_word, hit, slot_in_use, last
//
// A request passes through the front queue, then the back end steps through pop, decide
// and answer; a get miss adds an allocate step, a freed or evicted slot an evict step, a
// single flush a write-back step; flush all and free all walk all NUM_SLOTS slots; a get
// that must evict first scans the slot stamps.
// Reset (rst, synchronous) empties both queues and clears every slot; stamp counter to 1.
// A full result queue stalls back-end pushes; the front queue takes requests until full.
`timescale 1ns / 1ps
module register_slot_cache_lru import rsc_pkg::*; #(
  parameter int NUM_SLOTS      = DEF_NUM_SLOTS,
  parameter int NUM_GUEST_REGS = DEF_NUM_GUEST_REGS,
  parameter int WORDS_PER_REG  = DEF_WORDS_PER_REG,
  parameter int STAMP_WIDTH    = DEF_STAMP_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  command,
  input  logic [REG_W-1:0]  guest_reg,
  input  logic [WORD_W-1:0] word_sel,
  input  logic [SLOT_W-1:0] slot_sel,
  input  logic              load_on_miss,
  output logic              empty,
  input  logic              pop,
  output logic [KIND_W-1:0] kind,
  output logic [SLOT_W-1:0] slot,
  output logic [REG_W-1:0]  out_guest_reg,
  output logic [WORD_W-1:0] out_word,
  output logic              hit,
  output logic              slot_in_use,
  output logic              last
);
  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  res_t                    res;
  logic                    res_push;
  logic                    res_full;
  logic [$bits(res_t)-1:0] res_q;
  res_t                    head;

  rsc_front #(
    .NUM_SLOTS     (NUM_SLOTS),
    .NUM_GUEST_REGS(NUM_GUEST_REGS),
    .WORDS_PER_REG (WORDS_PER_REG)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .guest_reg   (guest_reg),
    .word_sel    (word_sel),
    .slot_sel    (slot_sel),
    .load_on_miss(load_on_miss),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty)
  );

  rsc_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  rsc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk  (clk),
    .rst  (rst),
    .wr_en(res_push),
    .din  (res),
    .full (res_full),
    .rd_en(pop),
    .dout (res_q),
    .empty(empty)
  );

  assign head          = res_t'(res_q);
  assign kind          = head.kind;
  assign slot          = head.slot;
  assign out_guest_reg = head.guest_reg;
  assign out_word      = head.word;
  assign hit           = head.hit;
  assign slot_in_use   = head.in_use;
  assign last          = head.last;
endmodule
